>>> rtl/abs_pkg.sv
// Shared constants, codes and types for the alternating bit sender.
package abs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MSG_BYTES = 20;
  localparam int PAYLOAD_W = 8 * MSG_BYTES;

  localparam int FQ_DEPTH  = 2;
  localparam int FQPTR_W   = $clog2(FQ_DEPTH);
  localparam int FQCNT_W   = $clog2(FQ_DEPTH + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  localparam logic [1:0] KIND_MSG  = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_SENT = 2'd1;
  localparam logic [1:0] EV_DROP = 2'd2;

  // Classified word passed from front to back
  typedef struct packed {
    logic [1:0]           kind;
    logic [PAYLOAD_W-1:0] payload;
    logic signed [15:0]   csum;
    logic                 ack_ok;
    logic                 ack_seq;
  } work_t;

  // Packet body kept in the pending store and as the last sent packet
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic signed [15:0]   csum;
  } pkt_t;

  typedef struct packed {
    logic [1:0]           event_res;
    logic                 send_seq;
    logic signed [15:0]   csum;
    logic [PAYLOAD_W-1:0] payload;
  } res_t;

endpackage

>>> rtl/abs_front.sv
// Front end: cuts the payload, computes checksums and pre-checks acknowledgements.
module abs_front (
  input  logic [1:0]             func,
  input  logic [63:0]            payload_lo,
  input  logic [63:0]            payload_mid,
  input  logic [31:0]            payload_hi,
  input  logic signed [31:0]     ack_seq,
  input  logic signed [31:0]     ack_num,
  input  logic signed [31:0]     ack_checksum,
  output abs_pkg::work_t         work
);
  import abs_pkg::*;

  function automatic logic [PAYLOAD_W-1:0] cut_payload(input logic [PAYLOAD_W-1:0] p);
    logic [PAYLOAD_W-1:0] r;
    logic                 keep;
    int                   i;
    int                   j;
    r = '0;
    for (i = 0; i < MSG_BYTES; i++) begin
      keep = 1'b1;
      for (j = 0; j < i; j++) begin
        if (p[8*j +: 8] == 8'd0) begin
          keep = 1'b0;
        end
      end
      if (keep) begin
        r[8*i +: 8] = p[8*i +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] weighted_sum(input logic [PAYLOAD_W-1:0] p);
    logic signed [15:0] total;
    logic [15:0]        v;
    int                 i;
    total = '0;
    for (i = 0; i < MSG_BYTES; i++) begin
      v = {{8{p[8*i+7]}}, p[8*i +: 8]};
      total = total + signed'(16'(v * 16'(i + 1)));
    end
    return total;
  endfunction

  logic [PAYLOAD_W-1:0] raw;
  logic [PAYLOAD_W-1:0] cut;
  logic signed [15:0]   raw_sum;
  logic                 seq_ok;

  assign raw     = {payload_hi, payload_mid, payload_lo};
  assign cut     = cut_payload(raw);
  assign raw_sum = weighted_sum(raw);
  assign seq_ok  = (ack_seq == 32'sd0) || (ack_seq == 32'sd1);

  always_comb begin
    work.kind    = func;
    work.payload = cut;
    work.csum    = weighted_sum(cut);
    work.ack_ok  = (raw[7:0] == 8'd0)
                && (ack_checksum == {{16{raw_sum[15]}}, raw_sum})
                && (ack_num == 32'sd1)
                && seq_ok;
    work.ack_seq = ack_seq[0];
  end

endmodule

>>> rtl/abs_fifo.sv
// Short queue of classified words between front and back.
module abs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  abs_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output abs_pkg::work_t pop_data
);
  import abs_pkg::*;

  work_t                slot [FQ_DEPTH];
  logic [FQPTR_W-1:0]   wr_ptr;
  logic [FQPTR_W-1:0]   rd_ptr;
  logic [FQCNT_W-1:0]   cnt;

  assign full      = (cnt == FQCNT_W'(FQ_DEPTH));
  assign not_empty = (cnt != '0);
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FQPTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FQPTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> rtl/abs_back.sv
// Back end: sender state, pending store, retransmit timer and result register.
module abs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_valid,
  input  abs_pkg::work_t     work,
  output logic               work_take,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output abs_pkg::res_t      res
);
  import abs_pkg::*;

  logic [15:0]        timeout_ticks;
  logic               seq_bit;
  logic               ready_flag;
  pkt_t               last_pkt;
  pkt_t               store [QUEUE_DEPTH];
  pkt_t               head_pkt;
  logic [QPTR_W-1:0]  head;
  logic [QPTR_W-1:0]  tail;
  logic [QCNT_W-1:0]  count;
  logic [15:0]        timer_count;
  logic               timer_armed;

  logic               seq_bit_next;
  logic               ready_flag_next;
  pkt_t               last_pkt_next;
  logic [QPTR_W-1:0]  head_next;
  logic [QPTR_W-1:0]  tail_next;
  logic [QCNT_W-1:0]  count_next;
  logic [15:0]        timer_count_next;
  logic               timer_armed_next;
  res_t               res_next;
  logic               push;
  logic               send;
  logic               send_seq;
  pkt_t               send_pkt;

  assign cfg_ready = 1'b1;
  assign work_take = work_valid && (!out_valid || out_ready);

  always_comb begin
    seq_bit_next     = seq_bit;
    ready_flag_next  = ready_flag;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    timer_count_next = timer_count;
    timer_armed_next = timer_armed;
    push             = 1'b0;
    send             = 1'b0;
    send_seq         = seq_bit;
    send_pkt         = last_pkt;
    res_next         = '0;
    if (work_take) begin
      case (work.kind)
        KIND_MSG: begin
          if (ready_flag) begin
            send     = 1'b1;
            send_seq = ~seq_bit;
            send_pkt = '{payload: work.payload, csum: work.csum};
          end else if (count == QCNT_W'(QUEUE_DEPTH)) begin
            res_next.event_res = EV_DROP;
          end else begin
            push       = 1'b1;
            tail_next  = (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
          end
        end
        KIND_ACK: begin
          if (work.ack_ok && (work.ack_seq == seq_bit)) begin
            ready_flag_next = 1'b1;
            if (count != '0) begin
              send       = 1'b1;
              send_seq   = ~seq_bit;
              send_pkt   = head_pkt;
              head_next  = (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
              count_next = count - 1'b1;
            end
          end
        end
        KIND_TICK: begin
          if (timer_armed) begin
            if (timer_count <= 16'd1) begin
              send     = 1'b1;
              send_seq = seq_bit;
              send_pkt = last_pkt;
            end else begin
              timer_count_next = timer_count - 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
      if (send) begin
        seq_bit_next       = send_seq;
        ready_flag_next    = 1'b0;
        timer_count_next   = timeout_ticks;
        timer_armed_next   = 1'b1;
        res_next.event_res = EV_SENT;
        res_next.send_seq  = send_seq;
        res_next.csum      = send_pkt.csum;
        res_next.payload   = send_pkt.payload;
      end
    end
    last_pkt_next = send ? send_pkt : last_pkt;
  end

  // Pending store with head word prefetched; bypass when writing the next head
  always_ff @(posedge clk) begin
    if (push) begin
      store[tail] <= '{payload: work.payload, csum: work.csum};
    end
    if (push && (tail == head_next)) begin
      head_pkt <= '{payload: work.payload, csum: work.csum};
    end else begin
      head_pkt <= store[head_next];
    end
    last_pkt <= last_pkt_next;
    if (work_take) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      seq_bit       <= 1'b0;
      ready_flag    <= 1'b1;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      timer_count   <= '0;
      timer_armed   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_ticks <= cfg_data;
      end
      seq_bit     <= seq_bit_next;
      ready_flag  <= ready_flag_next;
      head        <= head_next;
      tail        <= tail_next;
      count       <= count_next;
      timer_count <= timer_count_next;
      timer_armed <= timer_armed_next;
      if (work_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("pending count above depth");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> (count == '0))
    else $error("ready with messages pending");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with unequal pointers");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (work_take && (res_next.event_res == EV_DROP)) |-> (count == QCNT_W'(QUEUE_DEPTH)))
    else $error("drop while queue not full");

  a_send_arms: assert property (@(posedge clk) disable iff (rst)
    (work_take && send) |=> (timer_armed && !ready_flag))
    else $error("send did not arm timer");
`endif

endmodule

>>> rtl/alternating_bit_sender_core.sv
// Alternating bit sender: input word -> classify -> queue -> execute -> result word.
//
// Input channel (in_valid/in_ready): one word per item; func selects a message,
// an acknowledgement or a timer tick. Every accepted word yields exactly one
// result word on the output channel (out_valid/out_ready), in order.
// Configuration channel (cfg_valid/cfg_ready): writes timeout_ticks, always
// ready; write it only while the block is idle.
// A word accepted on the input is written into the queue, taken from there by the
// back end and registered in the result register, from which the output presents it.
// Throughput: one word per cycle unless the receiver stalls; the back end updates the
// sender state for one word per cycle and the front checksum trees are combinational.
// When the receiver stalls, the result register holds its word, the two-word
// queue between front and back fills, and in_ready drops once it is full.
// Reset: sequence bit 0, sender ready, pending store and timer empty,
// timeout_ticks 5000. No clearing pass is needed.
module alternating_bit_sender_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [63:0]         payload_lo,
  input  logic [63:0]         payload_mid,
  input  logic [31:0]         payload_hi,
  input  logic signed [31:0]  ack_seq,
  input  logic signed [31:0]  ack_num,
  input  logic signed [31:0]  ack_checksum,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          event_res,
  output logic                send_seq,
  output logic signed [15:0]  send_checksum,
  output logic [63:0]         send_payload_lo,
  output logic [63:0]         send_payload_mid,
  output logic [31:0]         send_payload_hi
);
  import abs_pkg::*;

  work_t front_work;
  work_t back_work;
  logic  fq_full;
  logic  fq_valid;
  logic  fq_pop;
  res_t  res;

  assign in_ready = !fq_full;

  abs_front u_front (
    .func         (func),
    .payload_lo   (payload_lo),
    .payload_mid  (payload_mid),
    .payload_hi   (payload_hi),
    .ack_seq      (ack_seq),
    .ack_num      (ack_num),
    .ack_checksum (ack_checksum),
    .work         (front_work)
  );

  abs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !fq_full),
    .push_data (front_work),
    .full      (fq_full),
    .pop       (fq_pop),
    .not_empty (fq_valid),
    .pop_data  (back_work)
  );

  abs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (fq_valid),
    .work       (back_work),
    .work_take  (fq_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign event_res        = res.event_res;
  assign send_seq         = res.send_seq;
  assign send_checksum    = res.csum;
  assign send_payload_lo  = res.payload[63:0];
  assign send_payload_mid = res.payload[127:64];
  assign send_payload_hi  = res.payload[159:128];

endmodule
